// ----- rtl/blsq_pkg.sv -----
// shared types, constants and LED pattern functions for the battery LED bar sequencer
package blsq_pkg;

    localparam int unsigned SOC_W      = 8;
    localparam int unsigned DUR_W      = 16;
    localparam int unsigned FAULT_W    = 16;
    localparam int unsigned LED_W      = 5;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned STEP_W     = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 8;

    localparam logic [LED_W-1:0]   LED_ALL     = 5'h1F;
    localparam logic [LED_W-1:0]   LED_OFF     = 5'h00;
    localparam logic [FAULT_W-1:0] FAULT_MASK  = 16'h2FFA;
    localparam logic [SOC_W-1:0]   FULL_LEVEL  = 8'd99;
    localparam logic [SOC_W-1:0]   LEVEL_20    = 8'd20;
    localparam logic [SOC_W-1:0]   LEVEL_40    = 8'd40;
    localparam logic [SOC_W-1:0]   LEVEL_60    = 8'd60;
    localparam logic [SOC_W-1:0]   LEVEL_80    = 8'd80;
    localparam logic [STEP_W-1:0]  ANIM_LAST   = 3'd5;
    localparam logic [1:0]         BAR_CHARGE  = 2'd1;
    localparam logic [1:0]         BAR_NORMAL  = 2'd0;

    localparam logic [DUR_W-1:0] TEMP_DEFAULT_RST = 16'd30;
    localparam logic [CNT_W-1:0] CHARGE_BLINK_RST = 8'd5;
    localparam logic [CNT_W-1:0] WATER_BLINK_RST  = 8'd2;
    localparam logic [CNT_W-1:0] ANIM_STEP_RST    = 8'd1;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_TEMP      = 3'd1,
        CMD_BOOT      = 3'd2,
        CMD_SHUTDOWN  = 3'd3,
        CMD_DISCHARGE = 3'd4,
        CMD_CHARGE    = 3'd5,
        CMD_WATER     = 3'd6,
        CMD_BAR_MODE  = 3'd7
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_DEFAULT = 2'd0,
        REG_CHARGE_BLINK = 2'd1,
        REG_WATER_BLINK  = 2'd2,
        REG_ANIM_STEP    = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        MODE_NORMAL   = 5'b00001,
        MODE_TEMP     = 5'b00010,
        MODE_BOOT_ON  = 5'b00100,
        MODE_BOOT_OFF = 5'b01000,
        MODE_SHUTDOWN = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [CNT_W-1:0] anim_step_ticks;
        logic [CNT_W-1:0] water_blink_ticks;
        logic [CNT_W-1:0] charge_blink_ticks;
        logic [DUR_W-1:0] temp_default_ticks;
    } cfg_t;

    // packed from the top: last member sits in the lowest bits
    typedef struct packed {
        logic               pad;
        logic               discharge_cutoff_error;
        logic               temp_break_error;
        logic [FAULT_W-1:0] fault_word;
        logic               startup_busy;
        logic               sleep_pending;
        logic [1:0]         bar_mode;
        logic               enable;
        logic [DUR_W-1:0]   duration;
        logic [SOC_W-1:0]   soc_value;
    } item_t;

    typedef struct packed {
        logic             water_alarm_active;
        logic             shutdown_active;
        logic             enter_deep_sleep;
        logic [LED_W-1:0] led_mask;
    } result_t;

    function automatic logic [LED_W-1:0] level_mask(input logic [SOC_W-1:0] soc);
        logic [LED_W-1:0] m;
        m    = 5'b00001;
        m[1] = (soc >= LEVEL_20);
        m[2] = (soc >= LEVEL_40);
        m[3] = (soc >= LEVEL_60);
        m[4] = (soc >= LEVEL_80);
        return m;
    endfunction

    function automatic logic [LED_W-1:0] fill_mask(input logic [STEP_W-1:0] step);
        logic [LED_W:0] ones;
        ones = (6'd1 << step) - 6'd1;
        return ones[LED_W-1:0];
    endfunction

    function automatic logic [LED_W-1:0] charge_mask(input logic [SOC_W-1:0] soc,
                                                    input logic           blink_on);
        logic [STEP_W-1:0] stage;
        logic [LED_W-1:0]  m;
        if (soc < LEVEL_20)
            stage = 3'd0;
        else if (soc < LEVEL_40)
            stage = 3'd1;
        else if (soc < LEVEL_60)
            stage = 3'd2;
        else if (soc < LEVEL_80)
            stage = 3'd3;
        else
            stage = 3'd4;
        m = fill_mask(stage);
        if (blink_on)
            m = m | (5'b00001 << stage);
        return m;
    endfunction

endpackage

// ----- rtl/blsq_cfg.sv -----
// configuration register bank with reset defaults
module blsq_cfg
    import blsq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_TEMP_DEFAULT: cfg_next.temp_default_ticks = cfg_data;
                REG_CHARGE_BLINK: cfg_next.charge_blink_ticks = cfg_data[CNT_W-1:0];
                REG_WATER_BLINK:  cfg_next.water_blink_ticks  = cfg_data[CNT_W-1:0];
                REG_ANIM_STEP:    cfg_next.anim_step_ticks    = cfg_data[CNT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_default_ticks <= TEMP_DEFAULT_RST;
            cfg_reg.charge_blink_ticks <= CHARGE_BLINK_RST;
            cfg_reg.water_blink_ticks  <= WATER_BLINK_RST;
            cfg_reg.anim_step_ticks    <= ANIM_STEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/blsq_core.sv -----
// display state and single-pass update of the LED bar for one request
module blsq_core
    import blsq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    step_en,
    input  cmd_t    cmd,
    input  item_t   item,
    output result_t res
);

    mode_t              mode_reg, mode_next;
    logic [STEP_W-1:0]  anim_step_reg, anim_step_next;
    logic [CNT_W-1:0]   anim_cnt_reg, anim_cnt_next;
    logic [DUR_W-1:0]   temp_cnt_reg, temp_cnt_next;
    logic [SOC_W-1:0]   temp_level_reg, temp_level_next;
    logic [DUR_W-1:0]   temp_dur_reg, temp_dur_next;
    logic               discharge_en_reg, discharge_en_next;
    logic               charge_en_reg, charge_en_next;
    logic               water_en_reg, water_en_next;
    logic               water_phase_reg, water_phase_next;
    logic [CNT_W-1:0]   water_cnt_reg, water_cnt_next;
    logic               blink_on_reg, blink_on_next;
    logic [CNT_W-1:0]   charge_cnt_reg, charge_cnt_next;
    logic               shutdown_reg, shutdown_next;
    logic [1:0]         bar_mode_reg, bar_mode_next;
    logic [LED_W-1:0]   led_reg, led_next;

    logic               sleep_pulse;
    logic               run_normal;
    logic               anim_due;
    logic               fault;
    logic [CNT_W-1:0]   anim_cnt_inc;
    logic [CNT_W-1:0]   water_cnt_inc;
    logic [CNT_W-1:0]   charge_cnt_inc;
    logic [DUR_W-1:0]   temp_cnt_inc;

    assign anim_cnt_inc   = anim_cnt_reg + 8'd1;
    assign water_cnt_inc  = water_cnt_reg + 8'd1;
    assign charge_cnt_inc = charge_cnt_reg + 8'd1;
    assign temp_cnt_inc   = temp_cnt_reg + 16'd1;
    assign anim_due       = (anim_cnt_inc >= cfg.anim_step_ticks);
    assign fault          = ((item.fault_word & FAULT_MASK) != '0) || item.temp_break_error
                            || item.discharge_cutoff_error;

    always_comb
    begin
        mode_next         = mode_reg;
        anim_step_next    = anim_step_reg;
        anim_cnt_next     = anim_cnt_reg;
        temp_cnt_next     = temp_cnt_reg;
        temp_level_next   = temp_level_reg;
        temp_dur_next     = temp_dur_reg;
        discharge_en_next = discharge_en_reg;
        charge_en_next    = charge_en_reg;
        water_en_next     = water_en_reg;
        water_phase_next  = water_phase_reg;
        water_cnt_next    = water_cnt_reg;
        blink_on_next     = blink_on_reg;
        charge_cnt_next   = charge_cnt_reg;
        shutdown_next     = shutdown_reg;
        bar_mode_next     = bar_mode_reg;
        led_next          = led_reg;
        sleep_pulse       = 1'b0;
        run_normal        = 1'b0;

        case (cmd)
            CMD_TICK:
            begin
                if (item.startup_busy)
                begin
                    led_next = led_reg;
                end
                else if (water_en_reg && (mode_reg != MODE_SHUTDOWN))
                begin
                    if (water_cnt_inc >= cfg.water_blink_ticks)
                    begin
                        water_cnt_next   = '0;
                        water_phase_next = !water_phase_reg;
                        led_next         = water_phase_reg ? LED_OFF : LED_ALL;
                    end
                    else
                    begin
                        water_cnt_next = water_cnt_inc;
                    end
                end
                else
                begin
                    if (water_en_reg)
                        led_next = LED_OFF;
                    // animation counter is shared by boot and shutdown
                    if ((mode_reg == MODE_BOOT_ON) || (mode_reg == MODE_BOOT_OFF)
                        || (mode_reg == MODE_SHUTDOWN))
                        anim_cnt_next = anim_due ? '0 : anim_cnt_inc;
                    case (mode_reg)
                        MODE_TEMP:
                        begin
                            if (temp_cnt_inc >= temp_dur_reg)
                            begin
                                temp_cnt_next = '0;
                                mode_next     = MODE_NORMAL;
                                led_next      = LED_OFF;
                            end
                            else
                            begin
                                temp_cnt_next = temp_cnt_inc;
                                led_next      = level_mask(temp_level_reg);
                            end
                        end
                        MODE_BOOT_ON:
                        begin
                            if (anim_due)
                            begin
                                if (anim_step_reg < ANIM_LAST)
                                begin
                                    anim_step_next = anim_step_reg + 3'd1;
                                    led_next       = fill_mask(anim_step_reg + 3'd1);
                                end
                                else
                                begin
                                    anim_step_next = '0;
                                    mode_next      = MODE_BOOT_OFF;
                                    led_next       = LED_OFF;
                                end
                            end
                        end
                        MODE_BOOT_OFF:
                        begin
                            if (anim_due)
                            begin
                                anim_step_next    = '0;
                                mode_next         = MODE_NORMAL;
                                discharge_en_next = 1'b1;
                                bar_mode_next     = BAR_NORMAL;
                                led_next          = level_mask(item.soc_value);
                            end
                        end
                        MODE_SHUTDOWN:
                        begin
                            if (anim_due)
                            begin
                                if (anim_step_reg < ANIM_LAST)
                                begin
                                    anim_step_next = anim_step_reg + 3'd1;
                                    led_next       = LED_ALL >> (anim_step_reg + 3'd1);
                                end
                                else
                                begin
                                    anim_step_next    = '0;
                                    mode_next         = MODE_NORMAL;
                                    shutdown_next     = 1'b0;
                                    discharge_en_next = 1'b0;
                                    charge_en_next    = 1'b0;
                                    led_next          = LED_OFF;
                                    sleep_pulse       = 1'b1;
                                end
                            end
                        end
                        MODE_NORMAL: run_normal = 1'b1;
                        default:     run_normal = 1'b1;
                    endcase

                    if (run_normal)
                    begin
                        if (item.sleep_pending)
                        begin
                            led_next = LED_OFF;
                        end
                        else if (charge_en_reg || (bar_mode_reg == BAR_CHARGE))
                        begin
                            if (charge_cnt_inc >= cfg.charge_blink_ticks)
                            begin
                                charge_cnt_next = '0;
                                blink_on_next   = !blink_on_reg;
                            end
                            else
                            begin
                                charge_cnt_next = charge_cnt_inc;
                            end
                            if (item.soc_value >= FULL_LEVEL)
                                led_next = LED_ALL;
                            else
                                led_next = charge_mask(item.soc_value, blink_on_next);
                        end
                        else if (discharge_en_reg)
                        begin
                            if (fault)
                                led_next = {4'b0000, !led_reg[0]};
                            else
                                led_next = level_mask(item.soc_value);
                        end
                        else
                        begin
                            led_next = LED_OFF;
                        end
                    end
                end
            end
            CMD_TEMP:
            begin
                if (!water_en_reg && (mode_reg != MODE_SHUTDOWN))
                begin
                    temp_level_next = item.soc_value;
                    temp_dur_next   = (item.duration != '0) ? item.duration
                                                            : cfg.temp_default_ticks;
                    temp_cnt_next   = '0;
                    mode_next       = MODE_TEMP;
                    led_next        = level_mask(item.soc_value);
                end
            end
            CMD_BOOT:
            begin
                if (!water_en_reg)
                begin
                    anim_step_next  = '0;
                    anim_cnt_next   = '0;
                    temp_cnt_next   = '0;
                    shutdown_next   = 1'b0;
                    temp_level_next = item.soc_value;
                    mode_next       = MODE_BOOT_ON;
                    led_next        = LED_OFF;
                end
            end
            CMD_SHUTDOWN:
            begin
                if (mode_reg != MODE_SHUTDOWN)
                begin
                    anim_step_next = '0;
                    anim_cnt_next  = '0;
                    temp_cnt_next  = '0;
                    shutdown_next  = 1'b1;
                    mode_next      = MODE_SHUTDOWN;
                    led_next       = LED_ALL;
                end
            end
            CMD_DISCHARGE:
            begin
                discharge_en_next = item.enable;
            end
            CMD_CHARGE:
            begin
                charge_en_next = item.enable;
                if (!item.enable)
                begin
                    blink_on_next   = 1'b1;
                    charge_cnt_next = '0;
                end
            end
            CMD_WATER:
            begin
                water_en_next = item.enable;
                if (!item.enable && water_en_reg)
                begin
                    water_phase_next = 1'b0;
                    water_cnt_next   = '0;
                    led_next         = LED_OFF;
                end
            end
            CMD_BAR_MODE:
            begin
                bar_mode_next = item.bar_mode;
            end
            default:
            begin
                bar_mode_next = item.bar_mode;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_NORMAL;
            anim_step_reg    <= '0;
            anim_cnt_reg     <= '0;
            temp_cnt_reg     <= '0;
            temp_level_reg   <= '0;
            temp_dur_reg     <= TEMP_DEFAULT_RST;
            discharge_en_reg <= 1'b0;
            charge_en_reg    <= 1'b0;
            water_en_reg     <= 1'b0;
            water_phase_reg  <= 1'b0;
            water_cnt_reg    <= '0;
            blink_on_reg     <= 1'b1;
            charge_cnt_reg   <= '0;
            shutdown_reg     <= 1'b0;
            bar_mode_reg     <= BAR_NORMAL;
            led_reg          <= LED_OFF;
        end
        else if (step_en)
        begin
            mode_reg         <= mode_next;
            anim_step_reg    <= anim_step_next;
            anim_cnt_reg     <= anim_cnt_next;
            temp_cnt_reg     <= temp_cnt_next;
            temp_level_reg   <= temp_level_next;
            temp_dur_reg     <= temp_dur_next;
            discharge_en_reg <= discharge_en_next;
            charge_en_reg    <= charge_en_next;
            water_en_reg     <= water_en_next;
            water_phase_reg  <= water_phase_next;
            water_cnt_reg    <= water_cnt_next;
            blink_on_reg     <= blink_on_next;
            charge_cnt_reg   <= charge_cnt_next;
            shutdown_reg     <= shutdown_next;
            bar_mode_reg     <= bar_mode_next;
            led_reg          <= led_next;
        end
    end

    assign res.led_mask           = led_next;
    assign res.enter_deep_sleep   = sleep_pulse;
    assign res.shutdown_active    = shutdown_next;
    assign res.water_alarm_active = water_en_next;

    // shutdown flag tracks the shutdown mode exactly
    assert property (@(posedge clk) disable iff (!rst_n)
        shutdown_reg == (mode_reg == MODE_SHUTDOWN))
        else $error("shutdown flag out of step with mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        anim_step_reg <= ANIM_LAST)
        else $error("animation step beyond last segment");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && sleep_pulse) |=> (mode_reg == MODE_NORMAL) && !discharge_en_reg
                                     && !charge_en_reg && (led_reg == LED_OFF))
        else $error("end of shutdown left state behind");

    assert property (@(posedge clk) disable iff (!rst_n)
        sleep_pulse |-> (mode_reg == MODE_SHUTDOWN) && (cmd == CMD_TICK))
        else $error("deep sleep pulse outside shutdown");

endmodule

// ----- rtl/battery_led_bar_sequencer.sv -----
// top level of the battery LED bar sequencer: request register, core, result register
//
// s_tuser carries the command code and s_tdata its operands; every request,
// ticks and commands alike, gives exactly one result on the m_ side.
// A request is taken into an input register, the display state is updated in
// one pass of logic and the result lands in an output register, from which it
// is shown on m_tdata. Throughput is one request per cycle while m_tready stays
// high; the input register refills in the same cycle that its request moves on
// into the output register. When the receiver stalls the output register holds
// its result, the input register holds one more request and s_tready then drops
// until m_tready returns. The cfg_ port writes the four timing registers one at
// a time; writes are meant for idle periods only.
// Reset clears the valid flags of both registers, the display state goes to
// normal mode with all LEDs off and the timing registers take their default values.
module battery_led_bar_sequencer
    import blsq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // soc_value, duration, enable, bar_mode, sleep_pending, startup_busy,
    // fault_word, temp_break_error, discharge_cutoff_error, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // cmd
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // led_mask, enter_deep_sleep, shutdown_active, water_alarm_active
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    result_t res;
    logic    in_valid_reg, in_valid_next;
    cmd_t    in_cmd_reg;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= cmd_t'(s_tuser);
            in_item_reg <= item_t'(s_tdata);
        end
        if (advance)
            out_data_reg <= res;
    end

    blsq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    blsq_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step_en (advance),
        .cmd     (in_cmd_reg),
        .item    (in_item_reg),
        .res     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_data_reg);

endmodule

// ----- bench/tb.sv -----
// testbench for the battery LED bar sequencer: directed and random requests checked against a display predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import blsq_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // soc_value, duration, enable, bar_mode, sleep_pending, startup_busy,
    // fault_word, temp_break_error, discharge_cutoff_error, zero pad
    logic [IN_DATA_W-1:0]  s_tdata;
    // cmd
    logic [2:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // led_mask, enter_deep_sleep, shutdown_active, water_alarm_active
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int send_idle_pct = 24;
    int recv_idle_pct = 66;
    int cycle_count   = 0;
    int errors        = 0;
    int requests_sent = 0;
    int results_seen  = 0;
    int sleep_pulses  = 0;
    int timing_sets   = 0;

    result_t display_q[$];
    result_t want_res;
    result_t got_res;

    // predictor copy of the timing registers
    logic [DUR_W-1:0] timing_temp_default;
    logic [CNT_W-1:0] timing_charge_blink;
    logic [CNT_W-1:0] timing_water_blink;
    logic [CNT_W-1:0] timing_anim_step;

    // predictor copy of the display state
    mode_t             ui_mode;
    logic [STEP_W-1:0] anim_step;
    logic [CNT_W-1:0]  anim_cnt;
    logic [DUR_W-1:0]  temp_cnt;
    logic [DUR_W-1:0]  temp_len;
    logic [SOC_W-1:0]  temp_level;
    logic              dis_en;
    logic              chg_en;
    logic              water_en;
    logic              water_on;
    logic [CNT_W-1:0]  water_cnt;
    logic              chg_on;
    logic [CNT_W-1:0]  chg_cnt;
    logic              shut_flag;
    logic [1:0]        bar_sel;
    logic [LED_W-1:0]  leds;

    battery_led_bar_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void clear_bar_state();
        timing_temp_default = 16'd30;
        timing_charge_blink = 8'd5;
        timing_water_blink  = 8'd2;
        timing_anim_step    = 8'd1;
        ui_mode    = MODE_NORMAL;
        anim_step  = '0;
        anim_cnt   = '0;
        temp_cnt   = '0;
        temp_len   = 16'd30;
        temp_level = '0;
        dis_en     = 1'b0;
        chg_en     = 1'b0;
        water_en   = 1'b0;
        water_on   = 1'b0;
        water_cnt  = '0;
        chg_on     = 1'b1;
        chg_cnt    = '0;
        shut_flag  = 1'b0;
        bar_sel    = BAR_NORMAL;
        leds       = LED_OFF;
    endfunction

    // charge thresholds, values above 100 count as 100
    function automatic logic [LED_W-1:0] soc_thresholds(input logic [SOC_W-1:0] soc);
        int unsigned lvl;
        logic [LED_W-1:0] m;
        lvl  = (soc > 8'd100) ? 100 : soc;
        m[0] = 1'b1;
        m[1] = lvl >= 20;
        m[2] = lvl >= 40;
        m[3] = lvl >= 60;
        m[4] = lvl >= 80;
        return m;
    endfunction

    function automatic bit anim_step_due();
        anim_cnt = anim_cnt + 8'd1;
        if (anim_cnt < timing_anim_step)
            return 1'b0;
        anim_cnt = '0;
        return 1'b1;
    endfunction

    function automatic void show_charge_bar(input logic [SOC_W-1:0] soc);
        int unsigned stage;
        logic [LED_W:0] bar;
        chg_cnt = chg_cnt + 8'd1;
        if (chg_cnt >= timing_charge_blink)
        begin
            chg_cnt = '0;
            chg_on  = ~chg_on;
        end
        if (soc >= FULL_LEVEL)
            leds = LED_ALL;
        else
        begin
            // below full, so the stage is at most four
            stage = soc / 20;
            bar   = (6'd1 << stage) - 6'd1;
            if (chg_on)
                bar[stage] = 1'b1;
            leds = bar[LED_W-1:0];
        end
    endfunction

    // one 100 ms tick, returns the deep sleep pulse
    function automatic bit advance_tick(input item_t it);
        logic [LED_W:0] fill;
        if (it.startup_busy)
            return 1'b0;
        if (water_en)
        begin
            if (ui_mode != MODE_SHUTDOWN)
            begin
                water_cnt = water_cnt + 8'd1;
                if (water_cnt >= timing_water_blink)
                begin
                    water_cnt = '0;
                    water_on  = ~water_on;
                    leds      = water_on ? LED_ALL : LED_OFF;
                end
                return 1'b0;
            end
            leds = LED_OFF;
        end
        case (ui_mode)
            MODE_TEMP:
            begin
                leds     = soc_thresholds(temp_level);
                temp_cnt = temp_cnt + 16'd1;
                if (temp_cnt >= temp_len)
                begin
                    temp_cnt = '0;
                    ui_mode  = MODE_NORMAL;
                    leds     = LED_OFF;
                end
                return 1'b0;
            end
            MODE_BOOT_ON:
            begin
                if (!anim_step_due())
                    return 1'b0;
                if (anim_step < ANIM_LAST)
                begin
                    anim_step = anim_step + 3'd1;
                    fill      = (6'd1 << anim_step) - 6'd1;
                    leds      = fill[LED_W-1:0];
                end
                else
                begin
                    anim_step = '0;
                    ui_mode   = MODE_BOOT_OFF;
                    leds      = LED_OFF;
                end
                return 1'b0;
            end
            MODE_BOOT_OFF:
            begin
                if (!anim_step_due())
                    return 1'b0;
                anim_step = '0;
                ui_mode   = MODE_NORMAL;
                dis_en    = 1'b1;
                bar_sel   = BAR_NORMAL;
                leds      = soc_thresholds(it.soc_value);
                return 1'b0;
            end
            MODE_SHUTDOWN:
            begin
                if (!anim_step_due())
                    return 1'b0;
                if (anim_step < ANIM_LAST)
                begin
                    anim_step = anim_step + 3'd1;
                    leds      = LED_ALL >> anim_step;
                    return 1'b0;
                end
                anim_step = '0;
                ui_mode   = MODE_NORMAL;
                shut_flag = 1'b0;
                dis_en    = 1'b0;
                chg_en    = 1'b0;
                leds      = LED_OFF;
                return 1'b1;
            end
            default: ;
        endcase
        if (it.sleep_pending)
            leds = LED_OFF;
        else if (chg_en || bar_sel == BAR_CHARGE)
            show_charge_bar(it.soc_value);
        else if (dis_en)
        begin
            if ((it.fault_word & FAULT_MASK) != '0 || it.temp_break_error
                || it.discharge_cutoff_error)
                leds = {4'b0000, ~leds[0]};
            else
                leds = soc_thresholds(it.soc_value);
        end
        else
            leds = LED_OFF;
        return 1'b0;
    endfunction

    function automatic result_t next_bar_display(input cmd_t cmd, input item_t it);
        result_t res;
        bit      pulse;
        pulse = 1'b0;
        case (cmd)
            CMD_TICK:
                pulse = advance_tick(it);
            CMD_TEMP:
                if (!water_en && ui_mode != MODE_SHUTDOWN)
                begin
                    temp_level = it.soc_value;
                    temp_len   = (it.duration != '0) ? it.duration : timing_temp_default;
                    temp_cnt   = '0;
                    ui_mode    = MODE_TEMP;
                    leds       = soc_thresholds(it.soc_value);
                end
            CMD_BOOT:
                if (!water_en)
                begin
                    anim_step  = '0;
                    anim_cnt   = '0;
                    temp_cnt   = '0;
                    shut_flag  = 1'b0;
                    temp_level = it.soc_value;
                    ui_mode    = MODE_BOOT_ON;
                    leds       = LED_OFF;
                end
            CMD_SHUTDOWN:
                if (ui_mode != MODE_SHUTDOWN)
                begin
                    anim_step = '0;
                    anim_cnt  = '0;
                    temp_cnt  = '0;
                    shut_flag = 1'b1;
                    ui_mode   = MODE_SHUTDOWN;
                    leds      = LED_ALL;
                end
            CMD_DISCHARGE:
                dis_en = it.enable;
            CMD_CHARGE:
            begin
                chg_en = it.enable;
                if (!it.enable)
                begin
                    chg_on  = 1'b1;
                    chg_cnt = '0;
                end
            end
            CMD_WATER:
                if (it.enable)
                    water_en = 1'b1;
                else
                begin
                    if (water_en)
                    begin
                        water_on  = 1'b0;
                        water_cnt = '0;
                        leds      = LED_OFF;
                    end
                    water_en = 1'b0;
                end
            CMD_BAR_MODE:
                bar_sel = it.bar_mode;
            default: ;
        endcase
        res.led_mask           = leds;
        res.enter_deep_sleep   = pulse;
        res.shutdown_active    = shut_flag;
        res.water_alarm_active = water_en;
        return res;
    endfunction

    function automatic void report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got_res = result_t'(m_tdata);
            if (display_q.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result, expected none, got %h", $time, m_tdata);
            end
            else
            begin
                want_res = display_q.pop_front();
                report_field("led_mask", want_res.led_mask, got_res.led_mask);
                report_field("enter_deep_sleep", want_res.enter_deep_sleep,
                             got_res.enter_deep_sleep);
                report_field("shutdown_active", want_res.shutdown_active,
                             got_res.shutdown_active);
                report_field("water_alarm_active", want_res.water_alarm_active,
                             got_res.water_alarm_active);
            end
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, display_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_request(input cmd_t cmd, input item_t it);
        result_t want;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = it;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = next_bar_display(cmd, it);
        if (want.enter_deep_sleep)
            sleep_pulses++;
        display_q.push_back(want);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        s_tvalid = 1'b0;
        while (display_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        case (idx)
            REG_TEMP_DEFAULT: timing_temp_default = val;
            REG_CHARGE_BLINK: timing_charge_blink = val[CNT_W-1:0];
            REG_WATER_BLINK:  timing_water_blink  = val[CNT_W-1:0];
            REG_ANIM_STEP:    timing_anim_step    = val[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_timing(input logic [DUR_W-1:0] temp_ticks,
                               input logic [CNT_W-1:0] charge_ticks,
                               input logic [CNT_W-1:0] water_ticks,
                               input logic [CNT_W-1:0] step_ticks);
        wait_for_results();
        write_reg(REG_TEMP_DEFAULT, temp_ticks);
        write_reg(REG_CHARGE_BLINK, {8'h00, charge_ticks});
        write_reg(REG_WATER_BLINK, {8'h00, water_ticks});
        write_reg(REG_ANIM_STEP, {8'h00, step_ticks});
        cfg_we = 1'b0;
        timing_sets++;
    endtask

    task automatic run_random_requests(input int count);
        cmd_t  cmd;
        item_t it;
        int    pick;
        for (int i = 0; i < count; i++)
        begin
            // now and then hold off until the pipeline is empty
            if ($urandom_range(0, 99) == 0)
                wait_for_results();
            pick = $urandom_range(0, 99);
            if (pick < 55)
                cmd = CMD_TICK;
            else if (pick < 63)
                cmd = CMD_TEMP;
            else if (pick < 68)
                cmd = CMD_BOOT;
            else if (pick < 72)
                cmd = CMD_SHUTDOWN;
            else if (pick < 80)
                cmd = CMD_DISCHARGE;
            else if (pick < 88)
                cmd = CMD_CHARGE;
            else if (pick < 93)
                cmd = CMD_WATER;
            else
                cmd = CMD_BAR_MODE;
            it = '0;
            it.soc_value = SOC_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                              : $urandom_range(0, 105));
            it.duration  = DUR_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                              : $urandom_range(0, 12));
            it.enable    = 1'($urandom_range(0, 1));
            it.bar_mode  = 2'($urandom_range(0, 3));
            it.sleep_pending = ($urandom_range(0, 9) == 0);
            it.startup_busy  = ($urandom_range(0, 9) == 0);
            pick = $urandom_range(0, 7);
            if (pick == 5)
                it.fault_word = FAULT_W'($urandom_range(0, 65535));
            else if (pick == 6)
                it.fault_word = FAULT_W'($urandom_range(0, 65535)) & ~FAULT_MASK;
            it.temp_break_error       = ($urandom_range(0, 11) == 0);
            it.discharge_cutoff_error = ($urandom_range(0, 11) == 0);
            // keep the alarm off most of the time so the other modes get reached
            if (cmd == CMD_WATER)
                it.enable = ($urandom_range(0, 2) == 0);
            else if (cmd == CMD_DISCHARGE)
                it.enable = ($urandom_range(0, 9) < 7);
            send_request(cmd, it);
        end
    endtask

    task automatic test_directed_cases();
        item_t it;
        it = '0;
        send_request(CMD_TICK, it);
        it.enable = 1'b1;
        send_request(CMD_DISCHARGE, it);
        it = '0;
        it.soc_value = 8'd255;
        send_request(CMD_TICK, it);
        it.soc_value              = 8'd79;
        it.fault_word             = 16'hFFFF;
        it.temp_break_error       = 1'b1;
        it.discharge_cutoff_error = 1'b1;
        send_request(CMD_TICK, it);
        // fault bits outside the mask only
        it.fault_word             = 16'hD005;
        it.temp_break_error       = 1'b0;
        it.discharge_cutoff_error = 1'b0;
        send_request(CMD_TICK, it);
        it = '0;
        it.soc_value     = 8'd100;
        it.sleep_pending = 1'b1;
        send_request(CMD_TICK, it);
        it.sleep_pending = 1'b0;
        it.startup_busy  = 1'b1;
        send_request(CMD_TICK, it);
        it = '0;
        it.bar_mode = 2'd3;
        send_request(CMD_BAR_MODE, it);
        it.bar_mode = BAR_CHARGE;
        send_request(CMD_BAR_MODE, it);
        it = '0;
        it.soc_value = FULL_LEVEL;
        send_request(CMD_TICK, it);
        it.enable = 1'b1;
        send_request(CMD_CHARGE, it);
        it.enable = 1'b0;
        send_request(CMD_CHARGE, it);
        // level display with default length
        it = '0;
        it.soc_value = 8'd60;
        send_request(CMD_TEMP, it);
        send_request(CMD_TICK, it);
        it.enable = 1'b1;
        send_request(CMD_WATER, it);
        // level and boot requests ignored under the alarm
        it.duration = 16'hFFFF;
        send_request(CMD_TEMP, it);
        send_request(CMD_BOOT, it);
        it = '0;
        repeat (2) send_request(CMD_TICK, it);
        send_request(CMD_SHUTDOWN, it);
        send_request(CMD_SHUTDOWN, it);
        send_request(CMD_TICK, it);
        send_request(CMD_WATER, it);
        repeat (5) send_request(CMD_TICK, it);
        it.soc_value = 8'd50;
        send_request(CMD_BOOT, it);
        send_request(CMD_TICK, it);
    endtask

    task automatic test_default_timing();
        run_random_requests(260);
    endtask

    task automatic test_fastest_timing();
        load_timing(16'd1, 8'd1, 8'd1, 8'd1);
        run_random_requests(260);
    endtask

    task automatic test_zero_periods();
        load_timing(16'd1, 8'd0, 8'd0, 8'd0);
        run_random_requests(260);
    endtask

    task automatic test_slowest_timing();
        load_timing(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        run_random_requests(250);
    endtask

    task automatic test_random_timing();
        repeat (2)
        begin
            load_timing(DUR_W'($urandom_range(1, 40)), CNT_W'($urandom_range(1, 8)),
                        CNT_W'($urandom_range(1, 8)), CNT_W'($urandom_range(1, 4)));
            run_random_requests(255);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_TICK;
        cfg_we    = 1'b0;
        cfg_index = REG_TEMP_DEFAULT;
        cfg_data  = '0;
        clear_bar_state();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_default_timing();
        test_fastest_timing();
        send_idle_pct = 66;
        recv_idle_pct = 24;
        test_zero_periods();
        test_slowest_timing();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_timing();

        wait_for_results();
        repeat (8) @(negedge clk);
        if (display_q.size() != 0)
        begin
            errors++;
            $display("%0t ns: %0d expected results never arrived", $time, display_q.size());
        end
        $display("covered %0d requests over all commands and %0d timing settings",
                 requests_sent, timing_sets + 1);
        $display("checked %0d results, %0d deep sleep pulses, %0d mismatches",
                 results_seen, sleep_pulses, errors);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
